// ----- hw/rtl/irfse_pkg.sv -----
// Shared types, constants and duration tables for the IR frame symbol encoder.
package irfse_pkg;

	// Default frame section sizes in bytes
	localparam int SECTION1_BYTES_DEF = 8;
	localparam int SECTION2_BYTES_DEF = 8;
	localparam int SECTION3_BYTES_DEF = 19;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int MARK_W   = 12;
	localparam int SPACE_W  = 15;
	localparam int KIND_W   = 3;
	localparam int STEP_W   = 4;

	// Preamble symbol count, header lengths
	localparam logic [STEP_W-1:0] PRE_COUNT  = STEP_W'(6);
	localparam logic [STEP_W-1:0] HDR_PRE_N  = STEP_W'(7);
	localparam logic [STEP_W-1:0] HDR_GAP_N  = STEP_W'(2);
	localparam logic [STEP_W-1:0] BITS_N     = STEP_W'(8);

	// Timing profile codes
	localparam logic PROF_CAPTURED = 1'b0;
	localparam logic PROF_NOMINAL  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRE  = 3'd0,
		KIND_LEAD = 3'd1,
		KIND_GAP  = 3'd2,
		KIND_ZERO = 3'd3,
		KIND_ONE  = 3'd4,
		KIND_TERM = 3'd5
	} irfse_kind_t;

	// One classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       profile;
		logic       pre;
		logic       gap;
		logic       term;
	} irfse_cmd_t;

	typedef struct packed {
		logic [MARK_W-1:0]  mark;
		logic [SPACE_W-1:0] space;
	} irfse_dur_t;

	// Duration lookup for a symbol kind under a timing profile
	function automatic irfse_dur_t sym_dur(input logic prof, input irfse_kind_t kind,
			input logic [2:0] pre_idx);
		irfse_dur_t d;
		d = '0;
		case (kind)
			KIND_PRE: begin
				case (pre_idx)
					3'd0:    d = '{12'd531, 15'd330};
					3'd1:    d = '{12'd510, 15'd356};
					3'd2:    d = '{12'd507, 15'd359};
					3'd3:    d = '{12'd504, 15'd362};
					3'd4:    d = '{12'd500, 15'd389};
					3'd5:    d = '{12'd474, 15'd25076};
					default: d = '0;
				endcase
			end
			KIND_LEAD: d = (prof == PROF_NOMINAL) ? '{12'd3360, 15'd1760} : '{12'd3462, 15'd1728};
			KIND_GAP:  d = (prof == PROF_NOMINAL) ? '{12'd360, 15'd32300} : '{12'd437, 15'd2743};
			KIND_ZERO: d = (prof == PROF_NOMINAL) ? '{12'd360, 15'd520}   : '{12'd438, 15'd428};
			KIND_ONE:  d = (prof == PROF_NOMINAL) ? '{12'd360, 15'd1370}  : '{12'd438, 15'd1294};
			KIND_TERM: d = (prof == PROF_NOMINAL) ? '{12'd360, 15'd0}     : '{12'd439, 15'd0};
			default:   d = '0;
		endcase
		return d;
	endfunction

endpackage

// ----- hw/rtl/irfse_if.sv -----
// Channel interfaces: frame bytes in, timed symbols out.
interface irfse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface irfse_sym_if;
	logic                         valid;
	logic                         ready;
	logic [irfse_pkg::MARK_W-1:0]  mark_us;
	logic [irfse_pkg::SPACE_W-1:0] dark_us;
	logic [irfse_pkg::KIND_W-1:0]  symbol_kind;
	logic                         last_of_item;
	logic                         frame_done;

	modport source (output valid, output mark_us, output dark_us, output symbol_kind,
		output last_of_item, output frame_done, input ready);
	modport sink (input valid, input mark_us, input dark_us, input symbol_kind,
		input last_of_item, input frame_done, output ready);
endinterface

// ----- hw/rtl/irfse_front.sv -----
// Front end: accepts frame bytes, tracks frame position and classifies each byte.
module irfse_front #(
	parameter int SECTION1_BYTES = irfse_pkg::SECTION1_BYTES_DEF,
	parameter int SECTION2_BYTES = irfse_pkg::SECTION2_BYTES_DEF,
	parameter int SECTION3_BYTES = irfse_pkg::SECTION3_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_data,
	irfse_byte_if.sink           frame_bytes,
	output logic                 push,
	output irfse_pkg::irfse_cmd_t push_cmd,
	input  logic                 push_ready
);

	localparam int FRAME_BYTES = SECTION1_BYTES + SECTION2_BYTES + SECTION3_BYTES;
	localparam int POS_W       = $clog2(FRAME_BYTES);

	logic             profile_q;
	logic [POS_W-1:0] pos_q;
	logic             is_last;

	// Timing profile register, nominal after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_q <= irfse_pkg::PROF_NOMINAL;
		end else if (cfg_we) begin
			profile_q <= cfg_data;
		end
	end

	assign frame_bytes.ready = push_ready;
	assign push              = frame_bytes.valid && push_ready;
	assign is_last           = (pos_q == POS_W'(FRAME_BYTES - 1));

	// Classify the byte by its place in the frame
	always_comb begin
		push_cmd.data    = frame_bytes.data_byte;
		push_cmd.profile = profile_q;
		push_cmd.pre     = (pos_q == '0);
		push_cmd.gap     = (pos_q == POS_W'(SECTION1_BYTES)) ||
			(pos_q == POS_W'(SECTION1_BYTES + SECTION2_BYTES));
		push_cmd.term    = is_last;
	end

	// Byte position within the frame, wraps after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= is_last ? '0 : pos_q + POS_W'(1);
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FRAME_BYTES - 1))
		else $error("frame position out of range");

endmodule

// ----- hw/rtl/irfse_queue.sv -----
// Short command queue decoupling the front end from the symbol sequencer.
module irfse_queue #(
	parameter int DEPTH = irfse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  irfse_pkg::irfse_cmd_t push_cmd,
	output logic                  push_ready,
	input  logic                  pop,
	output irfse_pkg::irfse_cmd_t head_cmd,
	output logic                  head_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	irfse_pkg::irfse_cmd_t slots_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ----- hw/rtl/irfse_back.sv -----
// Back end: steps through one command's symbols into the output register, one per cycle unless stalled.
module irfse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  irfse_pkg::irfse_cmd_t head_cmd,
	input  logic                  head_valid,
	output logic                  pop,
	irfse_sym_if.source           symbols
);

	localparam int SW = irfse_pkg::STEP_W;

	logic [SW-1:0]          step_q;
	logic [SW-1:0]          hdr_n;
	logic [SW-1:0]          total_n;
	logic [SW-1:0]          bit_pos;
	logic                   sym_last;
	logic                   advance;
	irfse_pkg::irfse_kind_t kind;
	logic [2:0]             pre_idx;
	irfse_pkg::irfse_dur_t  dur;

	logic                          out_valid_q;
	logic [irfse_pkg::MARK_W-1:0]  mark_q;
	logic [irfse_pkg::SPACE_W-1:0] space_q;
	logic [irfse_pkg::KIND_W-1:0]  kind_q;
	logic                          last_q;
	logic                          done_q;

	// Symbol count of the command at the head of the queue
	always_comb begin
		if (head_cmd.pre) begin
			hdr_n = irfse_pkg::HDR_PRE_N;
		end else if (head_cmd.gap) begin
			hdr_n = irfse_pkg::HDR_GAP_N;
		end else begin
			hdr_n = '0;
		end
		total_n  = hdr_n + irfse_pkg::BITS_N + SW'(head_cmd.term);
		sym_last = (step_q == total_n - SW'(1));
		bit_pos  = step_q - hdr_n;
	end

	// Decode the current step into a symbol kind
	always_comb begin
		pre_idx = step_q[2:0];
		if (step_q < hdr_n) begin
			if (head_cmd.pre) begin
				kind = (step_q < irfse_pkg::PRE_COUNT) ? irfse_pkg::KIND_PRE
					: irfse_pkg::KIND_LEAD;
			end else begin
				kind = (step_q == '0) ? irfse_pkg::KIND_GAP : irfse_pkg::KIND_LEAD;
			end
		end else if (bit_pos < irfse_pkg::BITS_N) begin
			kind = head_cmd.data[bit_pos[2:0]] ? irfse_pkg::KIND_ONE : irfse_pkg::KIND_ZERO;
		end else begin
			kind = irfse_pkg::KIND_TERM;
		end
		dur = irfse_pkg::sym_dur(head_cmd.profile, kind, pre_idx);
	end

	assign advance = head_valid && (!out_valid_q || symbols.ready);
	assign pop     = advance && sym_last;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (advance) begin
			step_q <= sym_last ? '0 : step_q + SW'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (symbols.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			mark_q  <= dur.mark;
			space_q <= dur.space;
			kind_q  <= kind;
			last_q  <= sym_last;
			done_q  <= (kind == irfse_pkg::KIND_TERM);
		end
	end

	assign symbols.valid        = out_valid_q;
	assign symbols.mark_us      = mark_q;
	assign symbols.dark_us      = space_q;
	assign symbols.symbol_kind  = kind_q;
	assign symbols.last_of_item = last_q;
	assign symbols.frame_done   = done_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> step_q < total_n)
		else $error("symbol step beyond command length");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> last_q)
		else $error("frame end symbol not last of its byte");

endmodule

// ----- hw/rtl/ir_frame_symbol_encoder_core.sv -----
// Top level of the IR frame symbol encoder: front end, command queue, symbol sequencer.
//
//  channel       dir  handshake        payload
//  frame_bytes   in   valid/ready      data_byte[7:0]
//  symbols       out  valid/ready      mark_us, dark_us, symbol_kind, last_of_item, frame_done
//  cfg           in   cfg_we (write)   cfg_data = profile select bit
//
// A byte becomes 8 to 15 symbols: 8 bits, plus 7 header symbols at frame start or
// 2 at a section start, plus the terminal at frame end. The sequencer emits one
// symbol per cycle while the output is not stalled.
// The front accepts a byte per cycle while the command queue has room.
// Reset clears frame position, queue and output valid; profile resets to nominal.
// A stalled output holds its symbol; the sequencer waits, the queue keeps filling.
module ir_frame_symbol_encoder_core #(
	parameter int SECTION1_BYTES = irfse_pkg::SECTION1_BYTES_DEF,
	parameter int SECTION2_BYTES = irfse_pkg::SECTION2_BYTES_DEF,
	parameter int SECTION3_BYTES = irfse_pkg::SECTION3_BYTES_DEF,
	parameter int QUEUE_DEPTH    = irfse_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_data,
	irfse_byte_if.sink   frame_bytes,
	irfse_sym_if.source  symbols
);

	logic                  push;
	logic                  push_ready;
	irfse_pkg::irfse_cmd_t push_cmd;
	logic                  pop;
	logic                  head_valid;
	irfse_pkg::irfse_cmd_t head_cmd;

	irfse_front #(
		.SECTION1_BYTES (SECTION1_BYTES),
		.SECTION2_BYTES (SECTION2_BYTES),
		.SECTION3_BYTES (SECTION3_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.frame_bytes (frame_bytes),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_ready  (push_ready)
	);

	irfse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.head_cmd   (head_cmd),
		.head_valid (head_valid)
	);

	irfse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.symbols    (symbols)
	);

endmodule
